>>> hdl/arit_pkg.sv
// ----------------------------------------------------------------------------
// arit_pkg
// Shared types and codes for the active rank index table.
// ----------------------------------------------------------------------------
package arit_pkg;

   localparam int FUNC_W = 3;
   localparam int IDX_W  = 10;
   localparam int SIZE_W = 11;
   localparam int ANS_W  = 11;

   localparam logic [FUNC_W-1:0] FUNC_START   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SELECT  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PAIR    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_FORWARD = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_REVERSE = 3'd4;

   localparam logic signed [ANS_W-1:0] ANSWER_NONE = 11'h7FF;

   typedef enum logic [2:0] {
      OP_START,
      OP_SELECT,
      OP_PAIR,
      OP_FORWARD,
      OP_REVERSE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                active;
      logic [IDX_W-1:0]    abs_index;
      logic [IDX_W-1:0]    rel_index;
      logic [SIZE_W-1:0]   abs_size;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      RP_NONE,
      RP_MARK,
      RP_ECHO_ABS,
      RP_ECHO_REL,
      RP_OUT_RANGE,
      RP_NOT_FOUND,
      RP_READ_FWD,
      RP_READ_REV
   } reply_type;

endpackage

>>> hdl/arit_front.sv
// ----------------------------------------------------------------------------
// arit_front
// Request decode and a two-entry command queue towards the execution side.
// ----------------------------------------------------------------------------
module arit_front
   import arit_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic                req_active,
   input  logic [IDX_W-1:0]    req_abs_index,
   input  logic [IDX_W-1:0]    req_rel_index,
   input  logic [SIZE_W-1:0]   req_abs_size,
   input  logic                back_clearing,
   output logic                cmd_valid,
   output cmd_type             cmd,
   input  logic                cmd_pop
);

   localparam int DEPTH = 2;

   cmd_type    q_ff [DEPTH];
   cmd_type    q_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       full;
   logic       known;
   logic       push;
   op_type     op;

   always_comb begin
      known = 1'b1;
      op    = OP_START;
      case (req_func)
         FUNC_START:   op = OP_START;
         FUNC_SELECT:  op = OP_SELECT;
         FUNC_PAIR:    op = OP_PAIR;
         FUNC_FORWARD: op = OP_FORWARD;
         FUNC_REVERSE: op = OP_REVERSE;
         default:      known = 1'b0;
      endcase
   end

   assign full      = (fill_ff == 2'(DEPTH));
   assign busy      = full | back_clearing;
   assign push      = start & ~busy & known;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   assign q_in      = '{op: op, active: req_active, abs_index: req_abs_index,
                        rel_index: req_rel_index, abs_size: req_abs_size};
   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign fill_in   = fill_ff + 2'(push) - 2'(cmd_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");
   assert property (@(posedge clock) disable iff (reset) fill_ff <= 2'(DEPTH))
      else $error("command queue overfilled");
   assert property (@(posedge clock) disable iff (reset) back_clearing |-> busy)
      else $error("request taken during clearing sweep");
`endif

endmodule

>>> hdl/arit_back.sv
// ----------------------------------------------------------------------------
// arit_back
// Execution side: rank maps, active marks, counters, clearing sweep, replies.
// ----------------------------------------------------------------------------
module arit_back
   import arit_pkg::*;
#(
   parameter int MAX_ABS = 1024,
   parameter int MAX_REL = 1024
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic                    csr_lookup_mode,
   input  logic                    cmd_valid,
   input  cmd_type                 cmd,
   output logic                    cmd_pop,
   output logic                    clearing,
   output logic                    rsp_valid,
   output logic signed [ANS_W-1:0] rsp_answer,
   output logic                    rsp_status
);

   localparam int AW   = $clog2(MAX_ABS);
   localparam int RW   = $clog2(MAX_REL);
   localparam int CNTW = $clog2(MAX_ABS + MAX_REL + 1);
   localparam int WW   = (CNTW > SIZE_W) ? CNTW : SIZE_W;
   localparam logic [AW-1:0] LAST = AW'(MAX_ABS - 1);

   logic          valid_mem [MAX_ABS];
   logic [RW-1:0] atr_mem   [MAX_ABS];
   logic [AW-1:0] rta_mem   [MAX_REL];

   state_type               state_ff, state_in;
   reply_type               reply_ff, reply_in;
   cmd_type                 cmd_ff, cmd_in;
   logic                    mode_ff, mode_in;
   logic [CNTW-1:0]         ac_ff, ac_in;
   logic [CNTW-1:0]         rc_ff, rc_in;
   logic [CNTW-1:0]         fp_ff, fp_in;
   logic [AW-1:0]           sweep_ff, sweep_in;
   logic                    valid_rd_ff;
   logic [RW-1:0]           atr_rd_ff;
   logic [AW-1:0]           rta_rd_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ANS_W-1:0] rsp_answer_ff, rsp_answer_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic          valid_we, valid_wd;
   logic [AW-1:0] valid_wa;
   logic          atr_we;
   logic [AW-1:0] atr_wa;
   logic [RW-1:0] atr_wd;
   logic          rta_we;
   logic [RW-1:0] rta_wa;
   logic [AW-1:0] rta_wd;
   logic [AW-1:0] abs_ra;
   logic [RW-1:0] rel_ra;

   logic [WW-1:0] ia_w, ir_w, size_w, ac_w, rc_w, fp_w, maxabs_w, maxrel_w;
   logic          csr_change;
   logic          pair_ok;

   assign ia_w     = WW'(cmd_ff.abs_index);
   assign ir_w     = WW'(cmd_ff.rel_index);
   assign size_w   = WW'(cmd_ff.abs_size);
   assign ac_w     = WW'(ac_ff);
   assign rc_w     = WW'(rc_ff);
   assign fp_w     = WW'(fp_ff);
   assign maxabs_w = WW'(MAX_ABS);
   assign maxrel_w = WW'(MAX_REL);
   assign abs_ra   = AW'(ia_w);
   assign rel_ra   = RW'(ir_w);

   assign csr_change = csr_valid & (csr_lookup_mode != mode_ff);
   assign pair_ok    = (ia_w < ac_w) && (ir_w < maxrel_w);
   assign clearing   = (state_ff == ST_CLEAR);

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sweep_ff == LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (cmd_ff.op)
               OP_START:   state_in = ST_CLEAR;
               OP_SELECT:  state_in = ST_IDLE;
               OP_PAIR:    state_in = pair_ok ? ST_FINISH : ST_IDLE;
               OP_FORWARD: state_in = ST_FINISH;
               OP_REVERSE: state_in = ST_FINISH;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
      if (csr_change) state_in = ST_CLEAR;
   end

   always_comb begin
      cmd_pop       = 1'b0;
      cmd_in        = cmd_ff;
      reply_in      = reply_ff;
      mode_in       = mode_ff;
      ac_in         = ac_ff;
      rc_in         = rc_ff;
      fp_in         = fp_ff;
      sweep_in      = sweep_ff;
      rsp_valid_in  = 1'b0;
      rsp_answer_in = rsp_answer_ff;
      rsp_status_in = rsp_status_ff;
      valid_we      = 1'b0;
      valid_wa      = abs_ra;
      valid_wd      = 1'b0;
      atr_we        = 1'b0;
      atr_wa        = abs_ra;
      atr_wd        = RW'(ir_w);
      rta_we        = 1'b0;
      rta_wa        = rel_ra;
      rta_wd        = abs_ra;
      case (state_ff)
         ST_CLEAR: begin
            valid_we = 1'b1;
            valid_wa = sweep_ff;
            sweep_in = sweep_ff + AW'(1);
         end
         ST_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd_valid) cmd_in = cmd;
         end
         ST_EXEC: begin
            case (cmd_ff.op)
               OP_START: begin
                  ac_in    = (size_w > maxabs_w) ? CNTW'(MAX_ABS) : CNTW'(size_w);
                  rc_in    = '0;
                  fp_in    = '0;
                  sweep_in = '0;
               end
               OP_SELECT: begin
                  if (fp_w < ac_w) begin
                     if (cmd_ff.active && (rc_w < maxrel_w)) begin
                        atr_we   = 1'b1;
                        atr_wa   = AW'(fp_ff);
                        atr_wd   = RW'(rc_ff);
                        rta_we   = 1'b1;
                        rta_wa   = RW'(rc_ff);
                        rta_wd   = AW'(fp_ff);
                        valid_we = 1'b1;
                        valid_wa = AW'(fp_ff);
                        valid_wd = 1'b1;
                        rc_in    = rc_ff + CNTW'(1);
                     end
                     fp_in = fp_ff + CNTW'(1);
                  end
               end
               OP_PAIR: begin
                  if (pair_ok) begin
                     atr_we   = 1'b1;
                     rta_we   = 1'b1;
                     reply_in = RP_MARK;
                  end
               end
               OP_FORWARD: begin
                  if (!mode_ff) begin
                     if (ac_w == '0)        reply_in = RP_ECHO_ABS;
                     else if (ia_w >= ac_w) reply_in = RP_OUT_RANGE;
                     else                   reply_in = RP_READ_FWD;
                  end else begin
                     if (rc_w == '0)            reply_in = RP_ECHO_ABS;
                     else if (ia_w < maxabs_w)  reply_in = RP_READ_FWD;
                     else                       reply_in = RP_NOT_FOUND;
                  end
               end
               OP_REVERSE: begin
                  if (rc_w == '0)                              reply_in = RP_ECHO_REL;
                  else if ((ir_w >= rc_w) || (ir_w >= maxrel_w)) reply_in = RP_OUT_RANGE;
                  else                                          reply_in = RP_READ_REV;
               end
               default: reply_in = RP_NONE;
            endcase
         end
         ST_FINISH: begin
            case (reply_ff)
               RP_MARK: begin
                  if (!valid_rd_ff) begin
                     valid_we = 1'b1;
                     valid_wd = 1'b1;
                     rc_in    = rc_ff + CNTW'(1);
                  end
               end
               RP_ECHO_ABS: begin
                  rsp_valid_in  = 1'b1;
                  rsp_answer_in = ANS_W'(cmd_ff.abs_index);
                  rsp_status_in = 1'b0;
               end
               RP_ECHO_REL: begin
                  rsp_valid_in  = 1'b1;
                  rsp_answer_in = ANS_W'(cmd_ff.rel_index);
                  rsp_status_in = 1'b0;
               end
               RP_OUT_RANGE: begin
                  rsp_valid_in  = 1'b1;
                  rsp_answer_in = ANSWER_NONE;
                  rsp_status_in = 1'b1;
               end
               RP_NOT_FOUND: begin
                  rsp_valid_in  = 1'b1;
                  rsp_answer_in = ANSWER_NONE;
                  rsp_status_in = 1'b0;
               end
               RP_READ_FWD: begin
                  rsp_valid_in  = 1'b1;
                  rsp_answer_in = valid_rd_ff ? ANS_W'(atr_rd_ff) : ANSWER_NONE;
                  rsp_status_in = 1'b0;
               end
               RP_READ_REV: begin
                  rsp_valid_in  = 1'b1;
                  rsp_answer_in = ANS_W'(rta_rd_ff);
                  rsp_status_in = 1'b0;
               end
               default: rsp_valid_in = 1'b0;
            endcase
         end
         default: cmd_pop = 1'b0;
      endcase
      if (csr_change) begin
         mode_in  = csr_lookup_mode;
         ac_in    = '0;
         rc_in    = '0;
         fp_in    = '0;
         sweep_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mode_ff      <= 1'b0;
         ac_ff        <= '0;
         rc_ff        <= '0;
         fp_ff        <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         reply_ff     <= RP_NONE;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         ac_ff        <= ac_in;
         rc_ff        <= rc_in;
         fp_ff        <= fp_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         reply_ff     <= reply_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (valid_we) valid_mem[valid_wa] <= valid_wd;
      valid_rd_ff <= valid_mem[abs_ra];
   end

   always_ff @(posedge clock) begin
      if (atr_we) atr_mem[atr_wa] <= atr_wd;
      atr_rd_ff <= atr_mem[abs_ra];
   end

   always_ff @(posedge clock) begin
      if (rta_we) rta_mem[rta_wa] <= rta_wd;
      rta_rd_ff <= rta_mem[rel_ra];
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_FINISH))
      else $error("response strobe without a finishing query");
   assert property (@(posedge clock) disable iff (reset) fp_ff <= ac_ff)
      else $error("fill pointer beyond table size");
   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> (state_ff == ST_IDLE))
      else $error("command taken outside idle");
   assert property (@(posedge clock) disable iff (reset)
      (($past(state_ff) == ST_CLEAR) && (state_ff == ST_IDLE)) |->
      ($past(sweep_ff) == LAST))
      else $error("clearing sweep left early");
`endif

endmodule

>>> hdl/active_rank_index_table_core.sv
// ----------------------------------------------------------------------------
// active_rank_index_table_core
// Two-way map between absolute positions and ranks of the active positions.
// A query passes the command queue, then the IDLE, EXEC and FINISH states of the back end
// before rsp_valid is strobed; the receiver cannot stall.
// Back end runs a selection or dropped pair through IDLE and EXEC, a stored pair or query
// through IDLE, EXEC and FINISH, and a start through IDLE, EXEC and the CLEAR sweep of the
// active-mark memory, one entry a cycle; a two-entry queue buffers requests.
// Reset and a change of lookup_mode run the same sweep with busy high.
// ----------------------------------------------------------------------------
module active_rank_index_table_core
   import arit_pkg::*;
#(
   parameter int MAX_ABS = 1024,
   parameter int MAX_REL = 1024
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic                    req_active,
   input  logic [IDX_W-1:0]        req_abs_index,
   input  logic [IDX_W-1:0]        req_rel_index,
   input  logic [SIZE_W-1:0]       req_abs_size,
   output logic                    rsp_valid,
   output logic signed [ANS_W-1:0] rsp_answer,
   output logic                    rsp_status,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_lookup_mode
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    clearing;

   assign csr_ready = 1'b1;

   arit_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_active    (req_active),
      .req_abs_index (req_abs_index),
      .req_rel_index (req_rel_index),
      .req_abs_size  (req_abs_size),
      .back_clearing (clearing),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   arit_back #(
      .MAX_ABS (MAX_ABS),
      .MAX_REL (MAX_REL)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid & csr_ready),
      .csr_lookup_mode (csr_lookup_mode),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_answer      (rsp_answer),
      .rsp_status      (rsp_status)
   );

endmodule
